/* rtl/core/wfcb_pkg.sv */
// Shared types, character codes and helper functions of the file pattern converter.
`default_nettype none

package wfcb_pkg;

  localparam int NAME_LEN = 8;
  localparam int TYPE_LEN = 3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_P = 8'h50;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_GAP  = 8'd32;

  // One operation for the back end: an optional drive write, up to two
  // pattern characters applied in order, and an optional finish.
  typedef struct packed {
    logic       drive_wr;
    logic [4:0] drive_val;
    logic       a_en;
    logic [7:0] a;
    logic       b_en;
    logic [7:0] b;
    logic       fin;
  } op_t;

  typedef struct packed {
    logic [4:0]  drive;
    logic [63:0] name_chars;
    logic [23:0] type_chars;
  } res_t;

  function automatic logic is_end(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      return c - CASE_GAP;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/wfcb_front.sv */
// Front end: skips leading blanks, detects the drive prefix and issues operations.
`default_nettype none

module wfcb_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [7:0]      ch,
  output logic                 op_push,
  output wfcb_pkg::op_t        op,
  input  wire logic            op_full
);
  import wfcb_pkg::*;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_HELD,
    PH_BODY
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held_char;
  logic [7:0] held_up;
  logic       accept;

  assign full    = op_full;
  assign accept  = push && !op_full;
  assign held_up = upcase(held_char);

  always_comb begin
    op          = '0;
    op_push     = 1'b0;
    phase_next  = phase;
    case (phase)
      PH_HELD: begin
        phase_next = PH_BODY;
        op_push    = accept;
        if (ch == CH_COLON) begin
          op.drive_wr = 1'b1;
          if (held_up >= CH_UPPER_A && held_up <= CH_UPPER_P) begin
            op.drive_val = 5'(held_up - CH_UPPER_A) + 5'd1;
          end
        end else if (is_end(held_char)) begin
          op.fin     = 1'b1;
          phase_next = PH_SKIP;
        end else begin
          op.a_en = 1'b1;
          op.a    = held_char;
          if (is_end(ch)) begin
            op.fin     = 1'b1;
            phase_next = PH_SKIP;
          end else begin
            op.b_en = 1'b1;
            op.b    = ch;
          end
        end
      end
      PH_BODY: begin
        op_push = accept;
        if (is_end(ch)) begin
          op.fin     = 1'b1;
          phase_next = PH_SKIP;
        end else begin
          op.a_en = 1'b1;
          op.a    = ch;
        end
      end
      default: begin
        if (ch == CH_NUL) begin
          op.fin  = 1'b1;
          op_push = accept;
        end else if (ch != CH_SPACE && ch != CH_TAB) begin
          phase_next = PH_HELD;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SKIP;
    end else if (accept) begin
      phase <= phase_next;
    end
    if (accept && phase == PH_SKIP) begin
      held_char <= ch;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wfcb_opq.sv */
// Two-entry operation queue between the front end and the back end.
`default_nettype none

module wfcb_opq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire wfcb_pkg::op_t op_in,
  output logic               valid,
  input  wire logic          pop,
  output wfcb_pkg::op_t      op_out
);
  import wfcb_pkg::*;

  op_t        entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign op_out  = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) begin
      entries[wr_ptr] <= op_in;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("operation queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("operation pushed into a full queue");
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    do_push |=> valid)
    else $error("queue empty after an operation was written");
`endif

endmodule

`default_nettype wire

/* rtl/core/wfcb_back.sv */
// Back end: builds the name and type fields and queues finished results.
`default_nettype none

module wfcb_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          op_valid,
  output logic               op_pop,
  input  wire wfcb_pkg::op_t op,
  output logic               empty,
  input  wire logic          pop,
  output logic [4:0]         drive,
  output logic [63:0]        name_chars,
  output logic [23:0]        type_chars
);
  import wfcb_pkg::*;

  typedef struct packed {
    logic [4:0]  drive_code;
    logic        in_type;
    logic [3:0]  name_fill;
    logic [1:0]  type_fill;
    logic [63:0] name_store;
    logic [23:0] type_store;
  } bst_t;

  localparam bst_t BST_RESET = '{
    drive_code: 5'd0,
    in_type:    1'b0,
    name_fill:  4'd0,
    type_fill:  2'd0,
    name_store: {8{CH_SPACE}},
    type_store: {3{CH_SPACE}}
  };

  function automatic bst_t apply_char(input bst_t s, input logic [7:0] raw);
    bst_t       r;
    logic [7:0] c;
    r = s;
    c = upcase(raw);
    if (c == CH_DOT) begin
      r.in_type   = 1'b1;
      r.type_fill = 2'd0;
    end else if (c == CH_STAR) begin
      if (!r.in_type) begin
        if (r.name_fill < 4'(NAME_LEN)) begin
          for (int i = 0; i < NAME_LEN; i++) begin
            if (4'(i) >= s.name_fill) begin
              r.name_store[(7 - i) * 8 +: 8] = CH_QMARK;
            end
          end
          r.name_fill = 4'(NAME_LEN);
        end
      end else if (r.type_fill < 2'(TYPE_LEN)) begin
        for (int i = 0; i < TYPE_LEN; i++) begin
          if (2'(i) >= s.type_fill) begin
            r.type_store[(2 - i) * 8 +: 8] = CH_QMARK;
          end
        end
        r.type_fill = 2'(TYPE_LEN);
      end
    end else if (!r.in_type) begin
      if (r.name_fill < 4'(NAME_LEN)) begin
        for (int i = 0; i < NAME_LEN; i++) begin
          if (4'(i) == s.name_fill) begin
            r.name_store[(7 - i) * 8 +: 8] = c;
          end
        end
        r.name_fill = s.name_fill + 4'd1;
      end
    end else if (r.type_fill < 2'(TYPE_LEN)) begin
      for (int i = 0; i < TYPE_LEN; i++) begin
        if (2'(i) == s.type_fill) begin
          r.type_store[(2 - i) * 8 +: 8] = c;
        end
      end
      r.type_fill = s.type_fill + 2'd1;
    end
    return r;
  endfunction

  bst_t       st;
  bst_t       st_next;
  bst_t       work;
  res_t       res_new;
  res_t       rq [2];
  logic       rq_wr;
  logic       rq_rd;
  logic [1:0] res_cnt;
  logic       res_push;
  logic       res_pop;

  assign op_pop   = op_valid && (!op.fin || res_cnt != 2'd2);
  assign res_push = op_pop && op.fin;
  assign empty    = (res_cnt == 2'd0);
  assign res_pop  = pop && !empty;

  assign drive      = rq[rq_rd].drive;
  assign name_chars = rq[rq_rd].name_chars;
  assign type_chars = rq[rq_rd].type_chars;

  always_comb begin
    work = st;
    if (op.drive_wr) begin
      work.drive_code = op.drive_val;
    end
    if (op.a_en) begin
      work = apply_char(work, op.a);
    end
    if (op.b_en) begin
      work = apply_char(work, op.b);
    end
    res_new.drive      = work.drive_code;
    res_new.name_chars = work.name_store;
    res_new.type_chars = work.type_store;
    if (!work.in_type) begin
      res_new.type_chars = {3{CH_QMARK}};
      if (work.name_fill == 4'd0) begin
        res_new.name_chars = {8{CH_QMARK}};
      end
    end
    st_next = op.fin ? BST_RESET : work;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= BST_RESET;
      rq_wr   <= 1'b0;
      rq_rd   <= 1'b0;
      res_cnt <= 2'd0;
    end else begin
      if (op_pop) begin
        st <= st_next;
      end
      if (res_push) begin
        rq_wr <= !rq_wr;
      end
      if (res_pop) begin
        rq_rd <= !rq_rd;
      end
      res_cnt <= res_cnt + 2'(res_push) - 2'(res_pop);
    end
    if (res_push) begin
      rq[rq_wr] <= res_new;
    end
  end

`ifndef NO_ASSERTIONS
  a_res_range: assert property (@(posedge clk) disable iff (rst) res_cnt <= 2'd2)
    else $error("result queue count out of range");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    st.name_fill <= 4'(NAME_LEN) && st.type_fill <= 2'(TYPE_LEN))
    else $error("fill count beyond field length");
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    res_push |=> st.name_fill == 4'd0 && st.type_fill == 2'd0 && !st.in_type
                 && st.drive_code == 5'd0)
    else $error("pattern state not cleared after an item was finished");
`endif

endmodule

`default_nettype wire

/* rtl/core/wildcard_filespec_to_fcb_unit.sv */
// Top level of the wildcard file pattern to directory-entry converter.
// Characters of a file pattern arrive on ch, one item per cycle, accepted
// when push is high and full is low. Leading spaces and tabs are skipped, an
// optional drive prefix such as "B:" is recognised, and the name and type are
// built up with letters upper-cased and stars expanded to question marks.
// A NUL, space, tab or carriage return ends the pattern and produces one
// result item: drive, name_chars and type_chars. The result is held on the
// output ports while empty is low and is taken when pop is high.
// The terminating character is written into the operation queue, and the back
// end then writes the result into the result queue, from which it is shown.
// The block accepts one character every cycle while full is low; the back
// end handles each operation as it pops it, and it applies a held character and
// the one after it together. When the receiver stalls, two results and two
// operations are buffered before full rises and input stops.
// Synchronous reset empties both queues and returns the block to its start
// state with blank name and type fields.
`default_nettype none

module wildcard_filespec_to_fcb_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  ch,
  output logic             empty,
  input  wire logic        pop,
  output logic [4:0]       drive,
  output logic [63:0]      name_chars,
  output logic [23:0]      type_chars
);
  import wfcb_pkg::*;

  op_t  fe_op;
  op_t  be_op;
  logic fe_push;
  logic q_full;
  logic q_valid;
  logic be_pop;

  wfcb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .ch      (ch),
    .op_push (fe_push),
    .op      (fe_op),
    .op_full (q_full)
  );

  wfcb_opq u_opq (
    .clk    (clk),
    .rst    (rst),
    .push   (fe_push),
    .full   (q_full),
    .op_in  (fe_op),
    .valid  (q_valid),
    .pop    (be_pop),
    .op_out (be_op)
  );

  wfcb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (q_valid),
    .op_pop     (be_pop),
    .op         (be_op),
    .empty      (empty),
    .pop        (pop),
    .drive      (drive),
    .name_chars (name_chars),
    .type_chars (type_chars)
  );

endmodule

`default_nettype wire
